// ===== sv/tsse_pkg.sv =====
`default_nettype none
package tsse_pkg;

  localparam int MAXW = 64;

  typedef logic signed [MAXW-1:0] sword_t;
  typedef logic [2:0] cfg_idx_t;

  typedef enum logic [2:0] {
    REG_MU     = 3'd0,
    REG_KAPPA  = 3'd1,
    REG_MASS2  = 3'd2,
    REG_LAMBDA = 3'd3,
    REG_IDX2   = 3'd4,
    REG_I2DX   = 3'd5
  } reg_idx_t;

  function automatic sword_t sat_w(logic signed [MAXW+1:0] v, int unsigned w);
    logic signed [MAXW+1:0] mx;
    logic signed [MAXW+1:0] mn;
    mx = (66'sd1 <<< (w - 1)) - 66'sd1;
    mn = -mx - 66'sd1;
    if (v > mx) return mx[MAXW-1:0];
    if (v < mn) return mn[MAXW-1:0];
    return v[MAXW-1:0];
  endfunction

  function automatic sword_t sadd(sword_t a, sword_t b, int unsigned w);
    return sat_w(66'(a) + 66'(b), w);
  endfunction

  function automatic sword_t ssub(sword_t a, sword_t b, int unsigned w);
    return sat_w(66'(a) - 66'(b), w);
  endfunction

  function automatic sword_t scale32(logic [63:0] v, int unsigned w, int unsigned f);
    logic [64:0] mx;
    mx = (65'd1 << (w - 1)) - 65'd1;
    if (f >= 32) begin
      if (65'(v) > (mx >> (f - 32))) return mx[63:0];
      return v << (f - 32);
    end
    if (65'(v >> (32 - f)) > mx) return mx[63:0];
    return v >> (32 - f);
  endfunction

endpackage
`default_nettype wire

// ===== sv/tsse_if.sv =====
`default_nettype none
interface tsse_in_if #(parameter int W = 48);
  logic               valid;
  logic               ready;
  logic signed [W-1:0] field_a;
  logic signed [W-1:0] field_b;
  logic signed [W-1:0] field_c;
  logic signed [W-1:0] speed_a;
  logic signed [W-1:0] speed_b;
  logic signed [W-1:0] speed_c;
  logic               first_point;
  logic               last_point;
  modport source (output valid, field_a, field_b, field_c, speed_a, speed_b, speed_c,
                  first_point, last_point, input ready);
  modport sink (input valid, field_a, field_b, field_c, speed_a, speed_b, speed_c,
                first_point, last_point, output ready);
endinterface

interface tsse_out_if #(parameter int W = 48);
  logic               valid;
  logic               ready;
  logic signed [W-1:0] accel_a;
  logic signed [W-1:0] accel_b;
  logic signed [W-1:0] accel_c;
  logic signed [W-1:0] energy_density;
  logic signed [W-1:0] pressure;
  logic signed [W-1:0] momentum_flux;
  logic               last_result;
  modport source (output valid, accel_a, accel_b, accel_c, energy_density, pressure,
                  momentum_flux, last_result, input ready);
  modport sink (input valid, accel_a, accel_b, accel_c, energy_density, pressure,
                momentum_flux, last_result, output ready);
endinterface

interface tsse_cfg_if import tsse_pkg::*; #(parameter int W = 48);
  logic         valid;
  logic         ready;
  cfg_idx_t     index;
  logic [W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/tsse_mul.sv =====
`default_nettype none
module tsse_mul #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  output logic                    done,
  output logic signed [W-1:0]     y
);

  localparam int H  = (W + 1) / 2;
  localparam int AW = 4 * H;
  localparam int PW = AW + 1;
  localparam logic signed [PW-1:0] PMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic [2*H-1:0] ma_r, mb_r;
  logic           neg_r, run_r, fin_r, done_r;
  logic [AW-1:0]  acc_r;
  logic [1:0]     k_r;
  logic signed [W-1:0] y_r;

  logic [W-1:0]   ua, ub, mag_a, mag_b;
  logic [H-1:0]   ah, bh;
  logic [2*H-1:0] pp;
  logic [1:0]     shamt;
  logic [AW-1:0]  ppw;
  logic signed [PW-1:0] prod, shr;
  logic signed [W-1:0]  sat;

  always_comb begin
    ua    = a;
    ub    = b;
    mag_a = ua[W-1] ? (~ua + 1'b1) : ua;
    mag_b = ub[W-1] ? (~ub + 1'b1) : ub;
    ah    = k_r[1] ? ma_r[2*H-1:H] : ma_r[H-1:0];
    bh    = k_r[0] ? mb_r[2*H-1:H] : mb_r[H-1:0];
    pp    = ah * bh;
    shamt = {1'b0, k_r[1]} + {1'b0, k_r[0]};
    ppw   = AW'(pp) << (H * shamt);
    prod  = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    shr   = prod >>> F;
    if (shr > PMAX) sat = PMAX[W-1:0];
    else if (shr < PMIN) sat = PMIN[W-1:0];
    else sat = shr[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ma_r  <= (2*H)'(mag_a);
        mb_r  <= (2*H)'(mag_b);
        neg_r <= a[W-1] ^ b[W-1];
        acc_r <= '0;
        k_r   <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_r + ppw;
        k_r   <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        y_r    <= sat;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule
`default_nettype wire

// ===== sv/tsse_div.sv =====
`default_nettype none
module tsse_div #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [W-1:0] n,
  input  wire logic signed [W-1:0] d,
  output logic                    done,
  output logic signed [W-1:0]     y
);

  localparam int NB = W + F;
  localparam int CW = $clog2(NB + 1);
  localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

  logic [NB-1:0] num_r, q_r;
  logic [W-1:0]  ud_r, rem_r;
  logic          neg_r, zero_r, npos_r, run_r, fin_r, done_r;
  logic [CW-1:0] cnt_r;
  logic signed [W-1:0] y_r;

  logic [W-1:0] un, ud, lim, ql;
  logic [W:0]   rem_s;
  logic         ge, over;
  logic [W-1:0] res;

  always_comb begin
    un    = n[W-1] ? (~$unsigned(n) + 1'b1) : $unsigned(n);
    ud    = d[W-1] ? (~$unsigned(d) + 1'b1) : $unsigned(d);
    rem_s = {rem_r, num_r[NB-1]};
    ge    = rem_s >= {1'b0, ud_r};
    lim   = neg_r ? QMIN : QMAX;
    ql    = q_r[W-1:0];
    over  = (|q_r[NB-1:W]) || (ql > lim);
    if (zero_r) res = npos_r ? QMAX : QMIN;
    else if (over) res = neg_r ? QMIN : QMAX;
    else res = neg_r ? (~ql + 1'b1) : ql;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= {un, {F{1'b0}}};
        ud_r   <= ud;
        rem_r  <= '0;
        q_r    <= '0;
        neg_r  <= n[W-1] ^ d[W-1];
        npos_r <= !n[W-1];
        zero_r <= (d == '0);
        cnt_r  <= CW'(NB);
        run_r  <= (d != '0);
        fin_r  <= (d == '0);
      end else if (run_r) begin
        rem_r <= ge ? W'(rem_s - {1'b0, ud_r}) : W'(rem_s);
        q_r   <= {q_r[NB-2:0], ge};
        num_r <= num_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        y_r    <= res;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule
`default_nettype wire

// ===== sv/tsse_lane.sv =====
`default_nettype none
module tsse_lane import tsse_pkg::*; #(
  parameter int W    = 48,
  parameter int F    = 32,
  parameter int LANE = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [W-1:0] cen [3],
  input  wire logic signed [W-1:0] lft,
  input  wire logic signed [W-1:0] rgt,
  input  wire logic signed [W-1:0] spd,
  input  wire logic signed [W-1:0] mu,
  input  wire logic signed [W-1:0] kappa,
  input  wire logic signed [W-1:0] mass2,
  input  wire logic signed [W-1:0] lambda,
  input  wire logic signed [W-1:0] idx2,
  input  wire logic signed [W-1:0] i2dx,
  output logic                    done,
  output logic signed [W-1:0]     accel,
  output logic signed [W-1:0]     kin,
  output logic signed [W-1:0]     grad,
  output logic signed [W-1:0]     mass_e,
  output logic signed [W-1:0]     mom,
  output logic signed [W-1:0]     v_pot
);

  localparam int O1 = (LANE == 0) ? 1 : 0;
  localparam int O2 = (LANE == 2) ? 1 : 2;
  localparam logic [W-1:0] ONE = (F < W - 1) ? (W'(1) << F) : {1'b0, {(W-1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE, S_T01, S_P, S_P2, S_KP, S_D2, S_LAPL, S_DP, S_PDP, S_MPDP, S_FORCE,
    S_PAIR, S_MC, S_GRADP, S_VV, S_DD, S_CC, S_MCC, S_MOM, S_MP2, S_VQ, S_C12,
    S_C20, S_LV, S_FIN
  } step_t;

  step_t st_r, st_nxt;
  logic  iss_r;

  logic signed [W-1:0] t01_r, p_r, p2_r, dd_r, d2_r, lapl_r, dpr_r, pdp_r, mpdp_r;
  logic signed [W-1:0] force_r, pair_r, dp_r, cc_r, mp2_r, vq_r, c12_r, c20_r;
  logic signed [W-1:0] acc_r, kin_r, grad_r, mass_r, mom_r, vpot_r;

  logic signed [W-1:0] mx, my, dn, dd, mres, dres;
  logic is_div, mstart, dstart, mdone, ddone, udone;

  function automatic logic signed [W-1:0] add_s(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    sword_t r;
    r = sadd(64'(a), 64'(b), W);
    return r[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sub_s(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    sword_t r;
    r = ssub(64'(a), 64'(b), W);
    return r[W-1:0];
  endfunction

  always_comb begin
    mx = cen[0];
    my = cen[1];
    dn = '0;
    dd = '0;
    case (st_r)
      S_T01:   begin mx = cen[0]; my = cen[1]; end
      S_P:     begin mx = t01_r; my = cen[2]; end
      S_P2:    begin mx = p_r; my = p_r; end
      S_KP:    begin mx = kappa; my = p2_r; end
      S_D2:    begin mx = dd_r; my = dd_r; end
      S_LAPL:  begin mx = sub_s(add_s(rgt, lft), add_s(cen[LANE], cen[LANE])); my = idx2; end
      S_DP:    begin mx = cen[O1]; my = cen[O2]; end
      S_PDP:   begin mx = p_r; my = dpr_r; end
      S_MPDP:  begin mx = mu; my = pdp_r; end
      S_FORCE: begin dn = sub_s('0, mpdp_r); dd = d2_r; end
      S_PAIR:  begin mx = lambda; my = add_s(cen[O1], cen[O2]); end
      S_MC:    begin mx = mass2; my = cen[LANE]; end
      S_GRADP: begin mx = sub_s(rgt, lft); my = i2dx; end
      S_VV:    begin mx = spd; my = spd; end
      S_DD:    begin mx = dp_r; my = dp_r; end
      S_CC:    begin mx = cen[LANE]; my = cen[LANE]; end
      S_MCC:   begin mx = mass2; my = cc_r; end
      S_MOM:   begin mx = spd; my = dp_r; end
      S_MP2:   begin mx = mu; my = p2_r; end
      S_VQ:    begin dn = mp2_r >>> 1; dd = dd_r; end
      S_C12:   begin mx = cen[1]; my = cen[2]; end
      S_C20:   begin mx = cen[2]; my = cen[0]; end
      S_LV:    begin mx = lambda; my = add_s(add_s(t01_r, c12_r), c20_r); end
      default: begin mx = cen[0]; my = cen[1]; end
    endcase
  end

  always_comb begin
    is_div = (st_r == S_FORCE) || (st_r == S_VQ);
    udone  = is_div ? ddone : mdone;
    mstart = (st_r != S_IDLE) && (st_r != S_FIN) && !iss_r && !is_div;
    dstart = (st_r != S_IDLE) && (st_r != S_FIN) && !iss_r && is_div;
    case (st_r)
      S_T01:   st_nxt = S_P;
      S_P:     st_nxt = S_P2;
      S_P2:    st_nxt = S_KP;
      S_KP:    st_nxt = S_D2;
      S_D2:    st_nxt = S_LAPL;
      S_LAPL:  st_nxt = S_DP;
      S_DP:    st_nxt = S_PDP;
      S_PDP:   st_nxt = S_MPDP;
      S_MPDP:  st_nxt = S_FORCE;
      S_FORCE: st_nxt = S_PAIR;
      S_PAIR:  st_nxt = S_MC;
      S_MC:    st_nxt = S_GRADP;
      S_GRADP: st_nxt = S_VV;
      S_VV:    st_nxt = S_DD;
      S_DD:    st_nxt = S_CC;
      S_CC:    st_nxt = S_MCC;
      S_MCC:   st_nxt = S_MOM;
      S_MOM:   st_nxt = (LANE == 0) ? S_MP2 : S_FIN;
      S_MP2:   st_nxt = S_VQ;
      S_VQ:    st_nxt = S_C12;
      S_C12:   st_nxt = S_C20;
      S_C20:   st_nxt = S_LV;
      S_LV:    st_nxt = S_FIN;
      default: st_nxt = S_IDLE;
    endcase
  end

  tsse_mul #(.W(W), .F(F)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(mx), .b(my), .done(mdone), .y(mres)
  );

  tsse_div #(.W(W), .F(F)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .n(dn), .d(dd), .done(ddone), .y(dres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      iss_r  <= 1'b0;
      vpot_r <= '0;
    end else begin
      if (st_r == S_IDLE) begin
        if (start) begin
          st_r  <= S_T01;
          iss_r <= 1'b0;
        end
      end else if (st_r == S_FIN) begin
        st_r <= S_IDLE;
      end else if (!iss_r) begin
        iss_r <= 1'b1;
      end else if (udone) begin
        iss_r <= 1'b0;
        st_r  <= st_nxt;
        case (st_r)
          S_T01:   t01_r  <= mres;
          S_P:     p_r    <= mres;
          S_P2:    p2_r   <= mres;
          S_KP:    dd_r   <= add_s(ONE, mres);
          S_D2:    d2_r   <= mres;
          S_LAPL:  lapl_r <= mres;
          S_DP:    dpr_r  <= mres;
          S_PDP:   pdp_r  <= mres;
          S_MPDP:  mpdp_r <= mres;
          S_FORCE: force_r <= dres;
          S_PAIR:  pair_r <= sub_s('0, mres);
          S_MC:    acc_r  <= add_s(add_s(sub_s(lapl_r, mres), force_r), pair_r);
          S_GRADP: dp_r   <= mres;
          S_VV:    kin_r  <= mres >>> 1;
          S_DD:    grad_r <= mres >>> 1;
          S_CC:    cc_r   <= mres;
          S_MCC:   mass_r <= mres >>> 1;
          S_MOM:   mom_r  <= mres;
          S_MP2:   mp2_r  <= mres;
          S_VQ:    vq_r   <= dres;
          S_C12:   c12_r  <= mres;
          S_C20:   c20_r  <= mres;
          S_LV:    vpot_r <= add_s(vq_r, mres);
          default: begin end
        endcase
      end
    end
  end

  assign done   = (st_r == S_FIN);
  assign accel  = acc_r;
  assign kin    = kin_r;
  assign grad   = grad_r;
  assign mass_e = mass_r;
  assign mom    = mom_r;
  assign v_pot  = vpot_r;

endmodule
`default_nettype wire

// ===== sv/tsse_merge.sv =====
`default_nettype none
module tsse_merge import tsse_pkg::*; #(
  parameter int W = 48
) (
  input  wire logic signed [W-1:0] kin [3],
  input  wire logic signed [W-1:0] grad [3],
  input  wire logic signed [W-1:0] mass_e [3],
  input  wire logic signed [W-1:0] mom [3],
  input  wire logic signed [W-1:0] v_pot,
  output logic signed [W-1:0]     t00,
  output logic signed [W-1:0]     t11,
  output logic signed [W-1:0]     t01
);

  function automatic logic signed [W-1:0] add_s(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    sword_t r;
    r = sadd(64'(a), 64'(b), W);
    return r[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sub_s(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    sword_t r;
    r = ssub(64'(a), 64'(b), W);
    return r[W-1:0];
  endfunction

  logic signed [W-1:0] k, g, m, p, kg;

  always_comb begin
    k   = add_s(add_s(kin[0], kin[1]), kin[2]);
    g   = add_s(add_s(grad[0], grad[1]), grad[2]);
    m   = add_s(add_s(mass_e[0], mass_e[1]), mass_e[2]);
    p   = add_s(add_s(mom[0], mom[1]), mom[2]);
    kg  = add_s(k, g);
    t00 = add_s(add_s(kg, m), v_pot);
    t11 = sub_s(sub_s(kg, m), v_pot);
    t01 = sub_s('0, p);
  end

endmodule
`default_nettype wire

// ===== sv/three_field_stencil_stress_energy.sv =====
// Three-field 1-D lattice stencil: accelerations and stress-energy terms.
// in_ch  : valid/ready stream of grid points (three fields, three speeds,
//          first_point / last_point marks). A point is taken when valid and
//          ready are both high.
// out_ch : valid/ready stream, one result item per interior point.
// cfg_ch : valid/ready register writes (index, data), always ready; write only
//          while no point is in flight.
// Boundary points are shifted into the window when taken. A point that completes a
// three-point window runs on three field lanes side by side, each a
// sequencer over one 4-step multiplier and one radix-2 divider; the field
// lane 0 also evaluates the potential. Its program of 21 multiplies and
// two divisions, run one at a time, sets when the result is valid; the next
// point is taken once that result has moved into the output register.
// A finished result sits in the output register; the next point is taken
// while it waits, and a further result waits in the lanes until it leaves.
// Reset (synchronous, rst_n low) clears the window and loads the register
// defaults.
`default_nettype none
module three_field_stencil_stress_energy import tsse_pkg::*; #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  tsse_in_if.sink   in_ch,
  tsse_out_if.source out_ch,
  tsse_cfg_if.sink  cfg_ch
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  localparam sword_t MU_RST    = ssub(64'sd0, scale32(64'd85899345920, W, F), W);
  localparam sword_t KAPPA_RST = scale32(64'd85899345920, W, F);
  localparam sword_t MASS_RST  = scale32(64'd4294967296, W, F);
  localparam sword_t IDX2_RST  = scale32(64'd1717128032315, W, F);
  localparam sword_t I2DX_RST  = scale32(64'd42938935542, W, F);

  logic signed [W-1:0] mu_r, lam_r;
  logic [W-2:0]        kap_r, m2_r, idx2_r, i2dx_r;

  logic signed [W-1:0] lft_r [3];
  logic signed [W-1:0] cen_r [3];
  logic signed [W-1:0] spd_r [3];
  logic signed [W-1:0] pf_r [3];
  logic signed [W-1:0] ps_r [3];
  logic                plast_r, busy_r;
  logic [1:0]          pts_r;
  logic [2:0]          ldone_r;

  logic                ov_r, olast_r;
  logic signed [W-1:0] oa_r [3];
  logic signed [W-1:0] oe_r, op_r, om_r;

  logic signed [W-1:0] in_f [3];
  logic signed [W-1:0] in_s [3];
  logic signed [W-1:0] sh_f [3];
  logic signed [W-1:0] sh_s [3];
  logic                acc, res, fin, sh_en, sh_clr, sh_last;
  logic [1:0]          eff_pts, base_pts;

  logic [2:0]          ldone;
  logic signed [W-1:0] l_acc [3];
  logic signed [W-1:0] l_kin [3];
  logic signed [W-1:0] l_grad [3];
  logic signed [W-1:0] l_mass [3];
  logic signed [W-1:0] l_mom [3];
  logic signed [W-1:0] l_vpot [3];
  logic signed [W-1:0] t00, t11, t01;

  assign in_f[0] = in_ch.field_a;
  assign in_f[1] = in_ch.field_b;
  assign in_f[2] = in_ch.field_c;
  assign in_s[0] = in_ch.speed_a;
  assign in_s[1] = in_ch.speed_b;
  assign in_s[2] = in_ch.speed_c;

  assign in_ch.ready  = !busy_r;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    acc     = in_ch.valid && !busy_r;
    eff_pts = in_ch.first_point ? 2'd0 : pts_r;
    res     = (eff_pts == 2'd2);
    fin     = busy_r && (&ldone_r) && (!ov_r || out_ch.ready);
    sh_en   = (acc && !res) || fin;
    sh_clr  = !busy_r && in_ch.first_point;
    sh_last = busy_r ? plast_r : in_ch.last_point;
    for (int i = 0; i < 3; i++) begin
      sh_f[i] = busy_r ? pf_r[i] : in_f[i];
      sh_s[i] = busy_r ? ps_r[i] : in_s[i];
    end
    base_pts = sh_clr ? 2'd0 : pts_r;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    tsse_lane #(.W(W), .F(F), .LANE(g)) u_lane (
      .clk(clk), .rst_n(rst_n), .start(acc && res),
      .cen(cen_r), .lft(lft_r[g]), .rgt(pf_r[g]), .spd(spd_r[g]),
      .mu(mu_r), .kappa({1'b0, kap_r}), .mass2({1'b0, m2_r}), .lambda(lam_r),
      .idx2({1'b0, idx2_r}), .i2dx({1'b0, i2dx_r}),
      .done(ldone[g]), .accel(l_acc[g]), .kin(l_kin[g]), .grad(l_grad[g]),
      .mass_e(l_mass[g]), .mom(l_mom[g]), .v_pot(l_vpot[g])
    );
  end

  tsse_merge #(.W(W)) u_merge (
    .kin(l_kin), .grad(l_grad), .mass_e(l_mass), .mom(l_mom), .v_pot(l_vpot[0]),
    .t00(t00), .t11(t11), .t01(t01)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r    <= MU_RST[W-1:0];
      kap_r   <= KAPPA_RST[W-2:0];
      m2_r    <= MASS_RST[W-2:0];
      lam_r   <= '0;
      idx2_r  <= IDX2_RST[W-2:0];
      i2dx_r  <= I2DX_RST[W-2:0];
      busy_r  <= 1'b0;
      ldone_r <= '0;
      pts_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lft_r[i] <= '0;
        cen_r[i] <= '0;
        spd_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_MU:     mu_r   <= cfg_ch.data;
          REG_KAPPA:  kap_r  <= cfg_ch.data[W-2:0];
          REG_MASS2:  m2_r   <= cfg_ch.data[W-2:0];
          REG_LAMBDA: lam_r  <= cfg_ch.data;
          REG_IDX2:   idx2_r <= cfg_ch.data[W-2:0];
          REG_I2DX:   i2dx_r <= cfg_ch.data[W-2:0];
          default: begin end
        endcase
      end

      ldone_r <= (acc && res) ? 3'b000 : (ldone_r | ldone);

      if (acc && res) begin
        busy_r  <= 1'b1;
        pf_r    <= in_f;
        ps_r    <= in_s;
        plast_r <= in_ch.last_point;
      end

      if (fin) begin
        busy_r  <= 1'b0;
        ov_r    <= 1'b1;
        oa_r    <= l_acc;
        oe_r    <= t00;
        op_r    <= t11;
        om_r    <= t01;
        olast_r <= plast_r;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end

      if (sh_en) begin
        if (sh_last) begin
          pts_r <= '0;
          for (int i = 0; i < 3; i++) begin
            lft_r[i] <= '0;
            cen_r[i] <= '0;
            spd_r[i] <= '0;
          end
        end else begin
          pts_r <= (base_pts == 2'd2) ? 2'd2 : base_pts + 2'd1;
          for (int i = 0; i < 3; i++) begin
            lft_r[i] <= sh_clr ? '0 : cen_r[i];
            cen_r[i] <= sh_f[i];
            spd_r[i] <= sh_s[i];
          end
        end
      end
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.accel_a        = oa_r[0];
  assign out_ch.accel_b        = oa_r[1];
  assign out_ch.accel_c        = oa_r[2];
  assign out_ch.energy_density = oe_r;
  assign out_ch.pressure       = op_r;
  assign out_ch.momentum_flux  = om_r;
  assign out_ch.last_result    = olast_r;

endmodule
`default_nettype wire

// ===== tb/tb_three_field_stencil_stress_energy.sv =====
`timescale 1ns / 1ps
module tb_three_field_stencil_stress_energy;
  import tsse_pkg::*;

  typedef logic signed [47:0] w_t;
  typedef logic signed [127:0] x_t;

  typedef struct {
    w_t   fa, fb, fc, sa, sb, sc;
    logic first, last;
  } point_t;

  typedef struct {
    w_t   acc_a, acc_b, acc_c, t00, t11, t01;
    logic last;
  } stress_t;

  localparam w_t WMAX = {1'b0, {47{1'b1}}};
  localparam w_t WMIN = {1'b1, {47{1'b0}}};
  localparam w_t ONE  = 48'sd4294967296;
  localparam w_t UMAX = WMAX;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  tsse_in_if  #(48) in_ch ();
  tsse_out_if #(48) out_ch ();
  tsse_cfg_if #(48) cfg_ch ();

  three_field_stencil_stress_energy u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  point_t  pending_pts[$];
  stress_t expected_res[$];
  int      errors = 0;
  bit      quiet = 0;

  // lattice model state
  w_t mu, kappa, mass2, lambda, idx2, i2dx;
  w_t win[6];
  w_t cspd[3];
  int seen;

  function automatic w_t sat(x_t v);
    if (v > x_t'(WMAX)) return WMAX;
    if (v < x_t'(WMIN)) return WMIN;
    return v[47:0];
  endfunction

  function automatic w_t add_s(w_t a, w_t b);
    return sat(x_t'(a) + x_t'(b));
  endfunction

  function automatic w_t sub_s(w_t a, w_t b);
    return sat(x_t'(a) - x_t'(b));
  endfunction

  function automatic w_t neg_s(w_t a);
    return sub_s(48'sd0, a);
  endfunction

  function automatic w_t qmul(w_t a, w_t b);
    x_t p;
    p = x_t'(a) * x_t'(b);
    return sat(p >>> 32);
  endfunction

  function automatic w_t qdiv(w_t n, w_t d);
    x_t q;
    if (d == 0) return (n >= 0) ? WMAX : WMIN;
    q = (x_t'(n) <<< 32) / x_t'(d);
    return sat(q);
  endfunction

  function automatic w_t halve(w_t x);
    return x >>> 1;
  endfunction

  task automatic clear_lattice();
    for (int i = 0; i < 6; i++) win[i] = '0;
    for (int i = 0; i < 3; i++) cspd[i] = '0;
    seen = 0;
  endtask

  task automatic stencil_step(point_t p);
    w_t f[3], s[3], c[3], lf[3];
    w_t pp, pp2, dd, dd2, kin, grad, mass_e, mom, pot, lapl, dpp, frc, pr, acc, dp;
    w_t accs[3];
    int o1, o2;
    stress_t r;
    f[0] = p.fa; f[1] = p.fb; f[2] = p.fc;
    s[0] = p.sa; s[1] = p.sb; s[2] = p.sc;
    if (p.first) clear_lattice();
    if (seen >= 2) begin
      for (int a = 0; a < 3; a++) begin
        lf[a] = win[a];
        c[a] = win[3 + a];
      end
      pp = qmul(qmul(c[0], c[1]), c[2]);
      pp2 = qmul(pp, pp);
      dd = add_s(ONE, qmul(kappa, pp2));
      dd2 = qmul(dd, dd);
      kin = 0; grad = 0; mass_e = 0; mom = 0;
      for (int a = 0; a < 3; a++) begin
        o1 = (a == 0) ? 1 : 0;
        o2 = (a == 2) ? 1 : 2;
        lapl = qmul(sub_s(add_s(f[a], lf[a]), add_s(c[a], c[a])), idx2);
        dpp = qmul(c[o1], c[o2]);
        frc = qdiv(neg_s(qmul(mu, qmul(pp, dpp))), dd2);
        pr = neg_s(qmul(lambda, add_s(c[o1], c[o2])));
        acc = add_s(add_s(sub_s(lapl, qmul(mass2, c[a])), frc), pr);
        dp = qmul(sub_s(f[a], lf[a]), i2dx);
        accs[a] = acc;
        kin = add_s(kin, halve(qmul(cspd[a], cspd[a])));
        grad = add_s(grad, halve(qmul(dp, dp)));
        mass_e = add_s(mass_e, halve(qmul(mass2, qmul(c[a], c[a]))));
        mom = add_s(mom, qmul(cspd[a], dp));
      end
      pot = add_s(qdiv(halve(qmul(mu, pp2)), dd),
                  qmul(lambda, add_s(add_s(qmul(c[0], c[1]), qmul(c[1], c[2])),
                                     qmul(c[2], c[0]))));
      r.acc_a = accs[0]; r.acc_b = accs[1]; r.acc_c = accs[2];
      r.t00 = add_s(add_s(add_s(kin, grad), mass_e), pot);
      r.t11 = sub_s(sub_s(add_s(kin, grad), mass_e), pot);
      r.t01 = neg_s(mom);
      r.last = p.last;
      expected_res.push_back(r);
    end
    for (int a = 0; a < 3; a++) begin
      win[a] = win[3 + a];
      win[3 + a] = f[a];
      cspd[a] = s[a];
    end
    if (seen < 2) seen++;
    if (p.last) clear_lattice();
  endtask

  // input driver
  int in_gap = 0;
  initial begin
    in_ch.valid = 0; in_ch.first_point = 0; in_ch.last_point = 0;
    in_ch.field_a = 0; in_ch.field_b = 0; in_ch.field_c = 0;
    in_ch.speed_a = 0; in_ch.speed_b = 0; in_ch.speed_c = 0;
    cfg_ch.valid = 0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    bit took;
    bit v;
    took = 0;
    v = in_ch.valid;
    if (!rst_n) begin
      v = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stencil_step(pending_pts.pop_front());
        took = 1;
      end
      if (in_ch.valid && !took) begin
        v = 1;
      end else if (in_gap > 0) begin
        in_gap--;
        v = 0;
      end else if (pending_pts.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 3);
          v = 0;
        end else begin
          v = 1;
          in_ch.field_a <= pending_pts[0].fa;
          in_ch.field_b <= pending_pts[0].fb;
          in_ch.field_c <= pending_pts[0].fc;
          in_ch.speed_a <= pending_pts[0].sa;
          in_ch.speed_b <= pending_pts[0].sb;
          in_ch.speed_c <= pending_pts[0].sc;
          in_ch.first_point <= pending_pts[0].first;
          in_ch.last_point <= pending_pts[0].last;
        end
      end else begin
        v = 0;
      end
    end
    in_ch.valid <= v;
  end

  // result monitor
  int out_gap = 0;

  task automatic check_field(string name, w_t exp_v, w_t act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    stress_t e;
    bit r;
    r = 0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual accel_a %0d",
                   $time, out_ch.accel_a);
        end else begin
          e = expected_res.pop_front();
          check_field("accel_a", e.acc_a, out_ch.accel_a);
          check_field("accel_b", e.acc_b, out_ch.accel_b);
          check_field("accel_c", e.acc_c, out_ch.accel_c);
          check_field("energy_density", e.t00, out_ch.energy_density);
          check_field("pressure", e.t11, out_ch.pressure);
          check_field("momentum_flux", e.t01, out_ch.momentum_flux);
          check_field("last_result", 48'(e.last), 48'(out_ch.last_result));
        end
      end
      if (quiet) begin
        r = 1;
      end else if (out_gap > 0) begin
        out_gap--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 3);
      end else begin
        r = 1;
      end
    end
    out_ch.ready <= r;
  end

  // stimulus helpers
  function automatic w_t rnd_word();
    w_t r;
    r = w_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2: return 48'sd0;
      3, 4: return r;
      default: return r >>> $urandom_range(10, 22);
    endcase
  endfunction

  function automatic w_t rnd_ureg();
    w_t r;
    r = {1'b0, $urandom, 15'($urandom_range(0, 32767))};
    if ($urandom_range(0, 5) == 0) return r;
    return r >> $urandom_range(8, 20);
  endfunction

  task automatic push_point(w_t f, w_t s, bit first, bit last);
    point_t p;
    p.fa = f; p.fb = f; p.fc = f; p.sa = s; p.sb = s; p.sc = s;
    p.first = first; p.last = last;
    pending_pts.push_back(p);
  endtask

  task automatic push_grid(int n, bit first, bit last);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.fa = rnd_word(); p.fb = rnd_word(); p.fc = rnd_word();
      p.sa = rnd_word(); p.sb = rnd_word(); p.sc = rnd_word();
      p.first = (first && i == 0) || ($urandom_range(0, 60) == 0);
      p.last = (last && i == n - 1) || ($urandom_range(0, 60) == 0);
      pending_pts.push_back(p);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, w_t val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_MU:     mu = val;
      REG_KAPPA:  kappa = {1'b0, val[46:0]};
      REG_MASS2:  mass2 = {1'b0, val[46:0]};
      REG_LAMBDA: lambda = val;
      REG_IDX2:   idx2 = {1'b0, val[46:0]};
      REG_I2DX:   i2dx = {1'b0, val[46:0]};
      default: ;
    endcase
  endtask

  task automatic write_all(w_t m, w_t k, w_t ms, w_t l, w_t ix, w_t i2);
    write_reg(REG_MU, m);
    write_reg(REG_KAPPA, k);
    write_reg(REG_MASS2, ms);
    write_reg(REG_LAMBDA, l);
    write_reg(REG_IDX2, ix);
    write_reg(REG_I2DX, i2);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_pts.size() != 0 || expected_res.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    int grid_len;
    while (n_items > 0) begin
      case ($urandom_range(0, 9))
        0: grid_len = $urandom_range(1, 2);
        9: grid_len = $urandom_range(8, 14);
        default: grid_len = $urandom_range(3, 7);
      endcase
      push_grid(grid_len, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
      n_items -= grid_len;
    end
    drain();
  endtask

  initial begin
    mu = -48'sd85899345920; kappa = 48'sd85899345920; mass2 = ONE; lambda = 0;
    idx2 = 48'sd1717128032315; i2dx = 48'sd42938935542;
    clear_lattice();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed, default registers
    push_point(WMAX, WMAX, 1, 0); push_point(WMAX, WMIN, 0, 0); push_point(WMAX, WMAX, 0, 1);
    push_point(WMIN, WMIN, 1, 0); push_point(WMIN, WMAX, 0, 0); push_point(WMIN, WMIN, 0, 1);
    push_point(WMAX, 0, 1, 0); push_point(WMIN, 0, 0, 0); push_point(WMAX, 0, 0, 0);
    push_point(0, 0, 0, 1);
    push_point(ONE, ONE, 1, 1);
    push_point(ONE, 0, 1, 0); push_point(-ONE, 0, 0, 1);
    push_point(ONE, ONE, 0, 0); push_point(-ONE, ONE, 0, 0); push_point(ONE, -ONE, 0, 1);
    push_point(ONE, 0, 1, 0); push_point(ONE, 0, 0, 0);
    push_point(-ONE, ONE, 1, 0); push_point(ONE, 0, 0, 0); push_point(0, 0, 0, 1);
    drain();

    write_all(rnd_word() >>> 8, rnd_ureg(), rnd_ureg(), rnd_word() >>> 12,
              rnd_ureg(), rnd_ureg());
    random_phase(270);
    write_all(WMIN, UMAX, UMAX, WMIN, UMAX, UMAX);
    random_phase(200);
    write_all(0, 0, 0, 0, 0, 0);
    random_phase(150);
    write_all(WMAX, 0, 0, WMAX, 0, UMAX);
    random_phase(150);
    write_all(rnd_word(), rnd_ureg(), rnd_ureg(), rnd_word(), rnd_ureg(), rnd_ureg());
    random_phase(300);
    quiet = 1;
    write_all(-48'sd85899345920, 48'sd85899345920, ONE, 48'sd1073741824,
              rnd_ureg(), rnd_ureg());
    random_phase(250);

    if (errors == 0) begin
      $display("[three_field_stencil_stress_energy] OK");
    end else begin
      $display("[three_field_stencil_stress_energy] ERROR");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("[three_field_stencil_stress_energy] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tsse_pkg.sv
sv/tsse_if.sv
sv/tsse_mul.sv
sv/tsse_div.sv
sv/tsse_lane.sv
sv/tsse_merge.sv
sv/three_field_stencil_stress_energy.sv
tb/tb_three_field_stencil_stress_energy.sv
